### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, reset or not.
`define CHK_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside of reset.
`define CHK_RUN(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### sv/rss_pkg.sv
// ---------------------------------------------------------------------------
// rss_pkg
// Types, constants and the key compare shared by the record sort unit.
// ---------------------------------------------------------------------------
package rss_pkg;

  localparam int IdW    = 20;
  localparam int PriceW = 22;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Sort modes
  localparam logic [1:0] MODE_PRICE_ASC  = 2'd0;
  localparam logic [1:0] MODE_PRICE_DESC = 2'd1;
  localparam logic [1:0] MODE_ID_ASC     = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]    record_id;
    logic [PriceW-1:0] price_cents;
    logic              last_in;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]    out_id;
    logic [PriceW-1:0] out_price_cents;
    logic              last_out;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
  } rec_t;

  // Classified command from front to back
  typedef struct packed {
    rec_t rec;
    logic store;
    logic last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SCAN,
    ST_SWAP_I,
    ST_SWAP_SEL,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  // True when cand is strictly better than cur under the given mode
  function automatic logic better(input logic [1:0] mode, input rec_t cand, input rec_t cur);
    logic res;
    case (mode)
      MODE_PRICE_ASC:  res = (cand.price < cur.price);
      MODE_PRICE_DESC: res = (cand.price > cur.price);
      MODE_ID_ASC:     res = (cand.id < cur.id);
      default:         res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

### sv/rss_front.sv
// ---------------------------------------------------------------------------
// rss_front
// Accepts records and marks each one as stored or dropped by set size.
// ---------------------------------------------------------------------------
module rss_front #(
  parameter int MAX_RECORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rss_pkg::in_t  item,
  output logic          full,
  input  logic          q_full,
  output logic          q_push,
  output rss_pkg::cmd_t q_cmd
);

  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [CW-1:0] fcnt;
  logic          accept;
  logic          store;

  // Classify the incoming beat
  assign accept = push && !q_full;
  assign store  = (fcnt < CW'(MAX_RECORDS));
  assign full   = q_full;
  assign q_push = accept;

  always_comb begin
    q_cmd.rec.id    = item.record_id;
    q_cmd.rec.price = item.price_cents;
    q_cmd.store     = store;
    q_cmd.last      = item.last_in;
  end

  // Count records of the current set; restart on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
    end else if (accept) begin
      if (item.last_in) begin
        fcnt <= '0;
      end else if (store) begin
        fcnt <= fcnt + CW'(1);
      end
    end
  end

endmodule

### sv/rss_fifo.sv
// ---------------------------------------------------------------------------
// rss_fifo
// Short command queue that decouples the front from the sort engine.
// ---------------------------------------------------------------------------
module rss_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rss_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output rss_pkg::cmd_t rdata,
  output logic          empty
);

  localparam int PW = rss_pkg::QPtrW;

  rss_pkg::cmd_t entries [rss_pkg::QDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (PW+1)'(rss_pkg::QDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

### sv/rss_back.sv
// ---------------------------------------------------------------------------
// rss_back
// Record store, selection sort engine with one comparator, and emitter.
// ---------------------------------------------------------------------------
module rss_back #(
  parameter int MAX_RECORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    sort_mode,
  input  logic          q_empty,
  input  rss_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          pop,
  output rss_pkg::out_t result,
  output logic          empty
);

  localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  rss_pkg::state_t state;
  rss_pkg::state_t state_next;

  // Record store
  rss_pkg::rec_t mem [MAX_RECORDS];
  rss_pkg::rec_t rd_q;

  logic [CW-1:0] n;
  logic [IW-1:0] i;
  logic [CW-1:0] j;
  logic [IW-1:0] sel;
  logic [IW-1:0] k;
  rss_pkg::rec_t best;
  rss_pkg::rec_t icopy;
  logic          rd_v;
  logic          rd_first;
  logic [IW-1:0] rd_idx;
  rss_pkg::out_t out_q;
  logic          out_v;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  rss_pkg::rec_t mem_wdata;
  logic [IW-1:0] rd_addr;
  logic          issue;
  logic          load_out;
  logic          j_more;
  logic          more_rows;
  logic          k_last;
  logic [CW-1:0] n_after;

  assign j_more    = (j < n);
  assign more_rows = ((CW'(i) + CW'(2)) < n);
  assign k_last    = ((CW'(k) + CW'(1)) == n);
  assign n_after   = n + CW'(q_cmd.store);
  assign load_out  = (state == rss_pkg::ST_EMIT_WR) && (!out_v || pop);
  assign empty     = !out_v;
  assign result    = out_q;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rss_pkg::ST_LOAD: begin
        if (!q_empty && q_cmd.last) begin
          if (n_after == '0) begin
            state_next = rss_pkg::ST_LOAD;
          end else if (n_after == CW'(1)) begin
            state_next = rss_pkg::ST_EMIT_RD;
          end else begin
            state_next = rss_pkg::ST_FETCH;
          end
        end
      end
      rss_pkg::ST_FETCH: state_next = rss_pkg::ST_SCAN;
      rss_pkg::ST_SCAN: begin
        if (!j_more && !rd_v) begin
          state_next = (sel != i) ? rss_pkg::ST_SWAP_I : rss_pkg::ST_NEXT;
        end
      end
      rss_pkg::ST_SWAP_I:   state_next = rss_pkg::ST_SWAP_SEL;
      rss_pkg::ST_SWAP_SEL: state_next = rss_pkg::ST_NEXT;
      rss_pkg::ST_NEXT: begin
        state_next = more_rows ? rss_pkg::ST_FETCH : rss_pkg::ST_EMIT_RD;
      end
      rss_pkg::ST_EMIT_RD: state_next = rss_pkg::ST_EMIT_WR;
      rss_pkg::ST_EMIT_WR: begin
        if (!out_v || pop) begin
          state_next = k_last ? rss_pkg::ST_LOAD : rss_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = rss_pkg::ST_LOAD;
    endcase
  end

  // Store port and queue controls per state
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = i;
    mem_wdata = q_cmd.rec;
    rd_addr   = i;
    issue     = 1'b0;
    case (state)
      rss_pkg::ST_LOAD: begin
        q_pop     = !q_empty;
        mem_we    = !q_empty && q_cmd.store;
        mem_waddr = n[IW-1:0];
        mem_wdata = q_cmd.rec;
      end
      rss_pkg::ST_FETCH: begin
        rd_addr = i;
        issue   = 1'b1;
      end
      rss_pkg::ST_SCAN: begin
        rd_addr = j[IW-1:0];
        issue   = j_more;
      end
      rss_pkg::ST_SWAP_I: begin
        mem_we    = 1'b1;
        mem_waddr = i;
        mem_wdata = best;
      end
      rss_pkg::ST_SWAP_SEL: begin
        mem_we    = 1'b1;
        mem_waddr = sel;
        mem_wdata = icopy;
      end
      rss_pkg::ST_EMIT_RD,
      rss_pkg::ST_EMIT_WR: begin
        rd_addr = k;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Write and read the store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rss_pkg::ST_LOAD;
      n     <= '0;
      rd_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      if (state == rss_pkg::ST_LOAD && !q_empty && q_cmd.store) begin
        n <= n + CW'(1);
      end else if (load_out && k_last) begin
        n <= '0;
      end
      if (load_out) begin
        out_v <= 1'b1;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

  // Sort and emit datapath
  always_ff @(posedge clk) begin
    rd_first <= (state == rss_pkg::ST_FETCH);
    rd_idx   <= rd_addr;
    case (state)
      rss_pkg::ST_LOAD: begin
        i <= '0;
        k <= '0;
      end
      rss_pkg::ST_FETCH: begin
        j <= CW'(i) + CW'(1);
      end
      rss_pkg::ST_NEXT: begin
        i <= i + IW'(1);
      end
      default: begin
        if (issue) begin
          j <= j + CW'(1);
        end
      end
    endcase
    // Track the best candidate of the current row
    if (rd_v) begin
      if (rd_first) begin
        best  <= rd_q;
        icopy <= rd_q;
        sel   <= rd_idx;
      end else if (rss_pkg::better(sort_mode, rd_q, best)) begin
        best <= rd_q;
        sel  <= rd_idx;
      end
    end
    if (load_out) begin
      out_q.out_id          <= rd_q.id;
      out_q.out_price_cents <= rd_q.price;
      out_q.last_out        <= k_last;
      k                     <= k + IW'(1);
    end
  end

endmodule

### sv/record_selection_sort_unit.sv
// ---------------------------------------------------------------------------
// record_selection_sort_unit: load, selection sort and emit of id/price records
// Load: one record per cycle through a 4-entry queue while it is not full. The
// sort does one key compare per cycle on the store read port, swaps through
// SWAP_I and SWAP_SEL, then emits via EMIT_RD and EMIT_WR. Synchronous reset
// clears counts, queue, output and sort_mode; the record store is left as is.
// ---------------------------------------------------------------------------
module record_selection_sort_unit #(
  parameter int MAX_RECORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rss_pkg::in_t  item,
  output logic          full,
  input  logic          pop,
  output rss_pkg::out_t result,
  output logic          empty,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  rss_pkg::cmd_t q_wcmd;
  rss_pkg::cmd_t q_rcmd;
  logic [1:0]    sort_mode;

  // Hold the sort mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= rss_pkg::MODE_PRICE_ASC;
    end else if (cfg_we) begin
      sort_mode <= cfg_data;
    end
  end

  rss_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wcmd)
  );

  rss_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .empty (q_empty)
  );

  rss_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .sort_mode (sort_mode),
    .q_empty   (q_empty),
    .q_cmd     (q_rcmd),
    .q_pop     (q_pop),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

endmodule

### sv/rss_checker.sv
// ---------------------------------------------------------------------------
// rss_checker
// Port-level checks of the record sort unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rss_checker (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          pop,
  input rss_pkg::out_t result,
  input logic          empty
);

  // Reset leaves no result waiting and room in the queue
  `CHK_ALWAYS(a_reset_idle, clk, rst |=> (empty && !full), "not idle after reset")

  // A waiting result that is not taken holds
  `CHK_RUN(a_result_hold, clk, rst, !empty && !pop |=> !empty && $stable(result), "not held")

  // A waiting result carries known bits
  `CHK_RUN(a_result_known, clk, rst, !empty |-> !$isunknown(result), "result unknown")

endmodule

bind record_selection_sort_unit rss_checker u_rss_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .pop      (pop),
  .result   (result),
  .empty    (empty)
);
